[sv/fru_pkg.sv]
// fru_pkg: shared constants for the unpolarized fresnel reflectance block
// register codes, reset values and fixed arithmetic widths
// no dependencies
`timescale 1ns / 1ps
package fru_pkg;

  localparam int FRACTION_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_INCIDENT_INDEX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_INDEX     = 1'b1;

  localparam logic [15:0] INCIDENT_INDEX_RST = 16'd21955;
  localparam logic [15:0] EXIT_INDEX_RST     = 16'd16384;

  // cosine magnitude limit (1.0 in q2.14)
  localparam logic [16:0] COS_ONE = 17'd16384;
  // 1.0 in q.28
  localparam logic [28:0] Q28_ONE = 29'h1000_0000;
  // 1.0 in q0.16 with the extra bit
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // squared cosine divider: 61-bit remainder, 32-bit divisor, 29-bit quotient
  localparam int QREM_W = 61;
  localparam int QDEN_W = 32;
  localparam int QQ_W   = 29;

endpackage

[sv/fru_div_cell.sv]
// fru_div_cell: one restoring division step, registered
// compares the remainder with the divisor shifted by SHIFT; no package use
`timescale 1ns / 1ps
module fru_div_cell #(
  parameter int REM_W = 8,
  parameter int DEN_W = 8,
  parameter int Q_W   = 8,
  parameter int SHIFT = 0,
  parameter int PAY_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [REM_W-1:0] rem_in,
  input  logic [DEN_W-1:0] den_in,
  input  logic [Q_W-1:0]   q_in,
  input  logic [PAY_W-1:0] pay_in,
  output logic             out_valid,
  output logic [REM_W-1:0] rem_out,
  output logic [DEN_W-1:0] den_out,
  output logic [Q_W-1:0]   q_out,
  output logic [PAY_W-1:0] pay_out
);

  localparam int CMP_W = (REM_W > DEN_W + SHIFT) ? REM_W : DEN_W + SHIFT;

  logic [CMP_W-1:0] rem_ext;
  logic [CMP_W-1:0] den_sh;
  logic [CMP_W-1:0] diff;
  logic             fits;

  assign rem_ext = CMP_W'(rem_in);
  assign den_sh  = CMP_W'(den_in) << SHIFT;
  assign fits    = rem_ext >= den_sh;
  assign diff    = rem_ext - den_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= fits ? REM_W'(diff) : rem_in;
      den_out <= den_in;
      q_out   <= Q_W'({q_in, fits});
      pay_out <= pay_in;
    end
  end

endmodule

[sv/fru_sqrt_cell.sv]
// fru_sqrt_cell: one digit step of the bitwise integer square root, registered
// trial bit is 4^K; no package use
`timescale 1ns / 1ps
module fru_sqrt_cell #(
  parameter int SW    = 9,
  parameter int K     = 0,
  parameter int PAY_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SW-1:0]    v_in,
  input  logic [SW-1:0]    r_in,
  input  logic [PAY_W-1:0] pay_in,
  output logic             out_valid,
  output logic [SW-1:0]    v_out,
  output logic [SW-1:0]    r_out,
  output logic [PAY_W-1:0] pay_out
);

  logic [SW-1:0] bit_val;
  logic [SW:0]   trial;
  logic          fits;

  assign bit_val = SW'(1) << (2 * K);
  assign trial   = (SW + 1)'(r_in) + (SW + 1)'(bit_val);
  assign fits    = (SW + 1)'(v_in) >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out   <= fits ? SW'((SW + 1)'(v_in) - trial) : v_in;
      r_out   <= fits ? (r_in >> 1) + bit_val : r_in >> 1;
      pay_out <= pay_in;
    end
  end

endmodule

[sv/fresnel_reflectance_unpolarized.sv]
// fresnel_reflectance_unpolarized: unpolarized fresnel reflectance pipeline
// throughput one request per cycle; a stalled result freezes the whole pipe
// the length is set by the 29-cell cos^2 divider, the root chain and the ratio dividers
// rst clears the valid bits and loads n1 = 21955, n2 = 16384 (q2.14)
// uses fru_pkg, fru_div_cell, fru_sqrt_cell
`timescale 1ns / 1ps
module fresnel_reflectance_unpolarized #(
  parameter int FRACTION_BITS = fru_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // incidence cosine request
  input  logic                            cos_valid,
  output logic                            cos_ready,
  input  logic signed [15:0]              incidence_cosine,
  // result
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [16:0]                     reflectance,
  output logic [16:0]                     transmittance,
  output logic                            internal_reflection,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [fru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fru_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int F     = FRACTION_BITS;
  localparam int SW    = 2 * F + 1;   // root operand width
  localparam int CT_W  = F + 1;       // cos_t, cos_i magnitude
  localparam int CI_W  = F + 2;       // signed cos_i
  localparam int PW    = F + 19;      // index times cosine
  localparam int NW    = PW + 1;      // sums and differences
  localparam int FR_W  = NW + F;      // ratio divider remainder
  localparam int QR_W  = fru_pkg::QREM_W;
  localparam int QD_W  = fru_pkg::QDEN_W;
  localparam int QQ_W  = fru_pkg::QQ_W;
  localparam int PAY_W = 17;          // tir, sign, cosine magnitude

  // configuration registers
  logic [15:0] incident_index;
  logic [15:0] exit_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      incident_index <= fru_pkg::INCIDENT_INDEX_RST;
      exit_index     <= fru_pkg::EXIT_INDEX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fru_pkg::CFG_INCIDENT_INDEX: incident_index <= cfg_data;
        fru_pkg::CFG_EXIT_INDEX:     exit_index     <= cfg_data;
        default: ;
      endcase
    end
  end

  // squares follow the registers; unchecked: hold stable while requests are in flight
  logic [31:0] n1sq;
  logic [31:0] n2sq;

  always_ff @(posedge clk) begin
    n1sq <= 32'(incident_index) * 32'(incident_index);
    n2sq <= 32'(exit_index) * 32'(exit_index);
  end

  // one enable for every stage: advance unless a finished result is held
  logic en;
  assign en        = !result_valid || result_ready;
  assign cos_ready = en;

  // stage 1: capture request
  logic        v1;
  logic [15:0] cin1;

  // stage 2: sign and clamped magnitude
  logic        v2;
  logic        neg2;
  logic [14:0] cmag2;
  logic [16:0] mag_raw;

  assign mag_raw = cin1[15] ? 17'(fru_pkg::ONE_Q16 - 17'(cin1)) : 17'(cin1);

  // stage 3: sin^2 in q.28
  logic        v3;
  logic        neg3;
  logic [14:0] cmag3;
  logic [28:0] s2_3;

  // stage 4: both sides of the tir test
  logic        v4;
  logic        neg4;
  logic [14:0] cmag4;
  logic [60:0] lhs4;
  logic [59:0] rhs4;

  // stage 5: tir flag and numerator of cos_t^2
  logic        v5;
  logic        neg5;
  logic        tir5;
  logic [14:0] cmag5;
  logic [60:0] diff5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= cos_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cin1  <= incidence_cosine;
      neg2  <= cin1[15];
      cmag2 <= (mag_raw > fru_pkg::COS_ONE) ? 15'(fru_pkg::COS_ONE) : 15'(mag_raw);
      neg3  <= neg2;
      cmag3 <= cmag2;
      s2_3  <= fru_pkg::Q28_ONE - 29'(30'(cmag2) * 30'(cmag2));
      neg4  <= neg3;
      cmag4 <= cmag3;
      lhs4  <= 61'(n1sq) * 61'(s2_3);
      rhs4  <= {n2sq, 28'd0};
      neg5  <= neg4;
      cmag5 <= cmag4;
      tir5  <= lhs4 >= 61'(rhs4);
      diff5 <= 61'(rhs4) - lhs4;
    end
  end

  // cos_t^2 = diff / n2^2, one quotient bit per cell
  logic             qv [0:QQ_W];
  logic [QR_W-1:0]  qr [0:QQ_W];
  logic [QD_W-1:0]  qd [0:QQ_W];
  logic [QQ_W-1:0]  qq [0:QQ_W];
  logic [PAY_W-1:0] qp [0:QQ_W];

  assign qv[0] = v5;
  assign qr[0] = diff5;
  assign qd[0] = n2sq;
  assign qq[0] = '0;
  assign qp[0] = {tir5, neg5, cmag5};

  for (genvar i = 0; i < QQ_W; i++) begin : g_qdiv
    fru_div_cell #(
      .REM_W(QR_W), .DEN_W(QD_W), .Q_W(QQ_W), .SHIFT(QQ_W - 1 - i), .PAY_W(PAY_W)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(qv[i]), .rem_in(qr[i]), .den_in(qd[i]), .q_in(qq[i]), .pay_in(qp[i]),
      .out_valid(qv[i+1]), .rem_out(qr[i+1]), .den_out(qd[i+1]), .q_out(qq[i+1]),
      .pay_out(qp[i+1])
    );
  end

  // rescale cos_t^2 from q.28 to q.2F
  logic [SW-1:0] sq_in;

  if (2 * F >= 28) begin : g_sq_up
    assign sq_in = SW'(qq[QQ_W]) << (2 * F - 28);
  end else begin : g_sq_dn
    assign sq_in = SW'(qq[QQ_W] >> (28 - 2 * F));
  end

  // cos_t = isqrt, one root bit per cell
  logic             sv  [0:F+1];
  logic [SW-1:0]    sval[0:F+1];
  logic [SW-1:0]    sr  [0:F+1];
  logic [PAY_W-1:0] sp  [0:F+1];

  assign sv[0]   = qv[QQ_W];
  assign sval[0] = sq_in;
  assign sr[0]   = '0;
  assign sp[0]   = qp[QQ_W];

  for (genvar i = 0; i <= F; i++) begin : g_sqrt
    fru_sqrt_cell #(
      .SW(SW), .K(F - i), .PAY_W(PAY_W)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sv[i]), .v_in(sval[i]), .r_in(sr[i]), .pay_in(sp[i]),
      .out_valid(sv[i+1]), .v_out(sval[i+1]), .r_out(sr[i+1]), .pay_out(sp[i+1])
    );
  end

  // cos_i magnitude rescaled from q2.14 to q.F
  logic [14:0]   cmag_s;
  logic [CT_W-1:0] cimag;

  assign cmag_s = sp[F+1][14:0];

  if (F >= 14) begin : g_ci_up
    assign cimag = CT_W'(cmag_s) << (F - 14);
  end else begin : g_ci_dn
    assign cimag = CT_W'(cmag_s >> (14 - F));
  end

  // stage 7: signed cos_i and cos_t
  logic                   v7;
  logic                   tir7;
  logic [CT_W-1:0]        ct7;
  logic signed [CI_W-1:0] ci7;

  // stage 8: index products
  logic                 v8;
  logic                 tir8;
  logic signed [PW-1:0] as8, bs8, ap8, bp8;

  // stage 9: numerators and denominators
  logic                 v9;
  logic                 tir9;
  logic signed [NW-1:0] nums9, dens9, nump9, denp9;

  // stage 10: magnitudes and saturation
  logic          v10;
  logic          tir10;
  logic          sats10, satp10;
  logic [NW-1:0] uns10, uds10, unp10, udp10;

  logic signed [CI_W-1:0] ct7s;
  logic signed [16:0]     n1s, n2s;
  logic [NW-1:0]          uns_c, uds_c, unp_c, udp_c;

  assign ct7s  = $signed({1'b0, ct7});
  assign n1s   = $signed({1'b0, incident_index});
  assign n2s   = $signed({1'b0, exit_index});
  assign uns_c = nums9[NW-1] ? NW'(-nums9) : NW'(nums9);
  assign uds_c = dens9[NW-1] ? NW'(-dens9) : NW'(dens9);
  assign unp_c = nump9[NW-1] ? NW'(-nump9) : NW'(nump9);
  assign udp_c = denp9[NW-1] ? NW'(-denp9) : NW'(denp9);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else if (en) begin
      v7  <= sv[F+1];
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tir7   <= sp[F+1][16];
      ct7    <= CT_W'(sr[F+1]);
      ci7    <= sp[F+1][15] ? -$signed({1'b0, cimag}) : $signed({1'b0, cimag});
      tir8   <= tir7;
      as8    <= PW'(n1s) * PW'(ci7);
      bs8    <= PW'(n2s) * PW'(ct7s);
      ap8    <= PW'(n1s) * PW'(ct7s);
      bp8    <= PW'(n2s) * PW'(ci7);
      tir9   <= tir8;
      nums9  <= NW'(as8) - NW'(bs8);
      dens9  <= NW'(as8) + NW'(bs8);
      nump9  <= NW'(ap8) - NW'(bp8);
      denp9  <= NW'(ap8) + NW'(bp8);
      tir10  <= tir9;
      sats10 <= (uds_c == '0) || (uns_c >= uds_c);
      satp10 <= (udp_c == '0) || (unp_c >= udp_c);
      uns10  <= uns_c;
      uds10  <= uds_c;
      unp10  <= unp_c;
      udp10  <= udp_c;
    end
  end

  // ratio dividers, F fraction bits each; saturated lanes divide zero
  logic             fvs [0:F];
  logic [FR_W-1:0]  frs [0:F];
  logic [NW-1:0]    fds [0:F];
  logic [F-1:0]     fqs [0:F];
  logic [1:0]       fps [0:F];
  logic             fvp [0:F];
  logic [FR_W-1:0]  frp [0:F];
  logic [NW-1:0]    fdp [0:F];
  logic [F-1:0]     fqp [0:F];
  logic             fpp [0:F];

  assign fvs[0] = v10;
  assign frs[0] = sats10 ? '0 : FR_W'(uns10) << F;
  assign fds[0] = uds10;
  assign fqs[0] = '0;
  assign fps[0] = {tir10, sats10};
  assign fvp[0] = v10;
  assign frp[0] = satp10 ? '0 : FR_W'(unp10) << F;
  assign fdp[0] = udp10;
  assign fqp[0] = '0;
  assign fpp[0] = satp10;

  for (genvar i = 0; i < F; i++) begin : g_frac
    fru_div_cell #(
      .REM_W(FR_W), .DEN_W(NW), .Q_W(F), .SHIFT(F - 1 - i), .PAY_W(2)
    ) u_s (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(fvs[i]), .rem_in(frs[i]), .den_in(fds[i]), .q_in(fqs[i]), .pay_in(fps[i]),
      .out_valid(fvs[i+1]), .rem_out(frs[i+1]), .den_out(fds[i+1]), .q_out(fqs[i+1]),
      .pay_out(fps[i+1])
    );
    fru_div_cell #(
      .REM_W(FR_W), .DEN_W(NW), .Q_W(F), .SHIFT(F - 1 - i), .PAY_W(1)
    ) u_p (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(fvp[i]), .rem_in(frp[i]), .den_in(fdp[i]), .q_in(fqp[i]), .pay_in(fpp[i]),
      .out_valid(fvp[i+1]), .rem_out(frp[i+1]), .den_out(fdp[i+1]), .q_out(fqp[i+1]),
      .pay_out(fpp[i+1])
    );
  end

  // stage 11: squared ratios; stage 12: mean of s and p
  logic         v11, v12;
  logic         tir11, tir12;
  logic         sats11, satp11;
  logic [F-1:0] sqs11, sqp11;
  logic [F:0]   rf12;
  logic [F:0]   rs_c, rp_c;
  logic [F+1:0] sum_c;

  assign rs_c  = sats11 ? (F + 1)'(1) << F : (F + 1)'(sqs11);
  assign rp_c  = satp11 ? (F + 1)'(1) << F : (F + 1)'(sqp11);
  assign sum_c = (F + 2)'(rs_c) + (F + 2)'(rp_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
      v12 <= 1'b0;
    end else if (en) begin
      v11 <= fvs[F];
      v12 <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tir11  <= fps[F][1];
      sats11 <= fps[F][0];
      satp11 <= fpp[F];
      sqs11  <= F'((2 * F)'(fqs[F]) * (2 * F)'(fqs[F]) >> F);
      sqp11  <= F'((2 * F)'(fqp[F]) * (2 * F)'(fqp[F]) >> F);
      tir12  <= tir11;
      rf12   <= (F + 1)'(sum_c >> 1);
    end
  end

  // rescale to q0.16 and clamp at 1.0
  logic [16:0] r16;
  logic [16:0] r16_sat;

  if (F >= 16) begin : g_out_dn
    assign r16 = 17'(rf12 >> (F - 16));
  end else begin : g_out_up
    assign r16 = 17'(rf12) << (16 - F);
  end

  assign r16_sat = (r16 > fru_pkg::ONE_Q16) ? fru_pkg::ONE_Q16 : r16;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= v12;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reflectance         <= tir12 ? fru_pkg::ONE_Q16 : r16_sat;
      transmittance       <= tir12 ? 17'd0 : fru_pkg::ONE_Q16 - r16_sat;
      internal_reflection <= tir12;
    end
  end

  // reflectance and transmittance always split 1.0
  a_sum_one: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (17'(reflectance + transmittance) == fru_pkg::ONE_Q16))
    else $error("reflectance and transmittance do not sum to 1.0");

  // total internal reflection reports full reflection
  a_tir_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && internal_reflection) |-> (reflectance == fru_pkg::ONE_Q16))
    else $error("internal reflection without full reflectance");

  // a held result stays valid and unchanged until taken
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(reflectance)))
    else $error("result changed while held");

endmodule

[tb/testbench.sv]
// testbench for fresnel_reflectance_unpolarized: random and directed cosines
// under several index settings, checked against an in-bench fixed-point predictor
// depends on fru_pkg and the block rtl
`timescale 1ns / 1ps
module testbench;

  localparam int FB = fru_pkg::FRACTION_BITS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cos_valid = 1'b0;
  logic cos_ready;
  logic signed [15:0] incidence_cosine = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [16:0] reflectance;
  logic [16:0] transmittance;
  logic internal_reflection;
  logic cfg_we = 1'b0;
  logic [fru_pkg::CFG_IDX_W-1:0] cfg_index = fru_pkg::CFG_INCIDENT_INDEX;
  logic [fru_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  typedef struct packed {
    logic [16:0] refl;
    logic [16:0] trans;
    logic        tir;
  } fresnel_t;

  fresnel_t expected_fresnel[$];
  logic [15:0] n1_model = fru_pkg::INCIDENT_INDEX_RST;
  logic [15:0] n2_model = fru_pkg::EXIT_INDEX_RST;
  int errors = 0;
  int out_wait = 0;

  // clock, period 8 ns
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fresnel_reflectance_unpolarized #(.FRACTION_BITS(FB)) i_dut (
    .clk(clk), .rst(rst),
    .cos_valid(cos_valid), .cos_ready(cos_ready), .incidence_cosine(incidence_cosine),
    .result_valid(result_valid), .result_ready(result_ready),
    .reflectance(reflectance), .transmittance(transmittance),
    .internal_reflection(internal_reflection),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // squared amplitude ratio, saturating at 1.0
  function automatic longint unsigned ratio_sq(longint num, longint den);
    longint unsigned un, ud, rem, q;
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    if (ud == 0 || un >= ud) return 64'd1 << FB;
    rem = un;
    q = 0;
    for (int i = 0; i < FB; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= ud) begin
        rem -= ud;
        q |= 1;
      end
    end
    return (q * q) >> FB;
  endfunction

  function automatic fresnel_t predict_fresnel(logic [15:0] raw);
    fresnel_t o;
    bit neg;
    longint unsigned cmag, s2, lhs, rhs, q, ct, cim, rs, rp, rf, n1, n2;
    longint ci, a, b;
    n1 = n1_model;
    n2 = n2_model;
    neg = raw[15];
    cmag = neg ? 65536 - raw : raw;
    if (cmag > 16384) cmag = 16384;
    s2 = (64'd1 << 28) - cmag * cmag;
    lhs = n1 * n1 * s2;
    rhs = (n2 * n2) << 28;
    if (lhs >= rhs) begin
      o.refl = fru_pkg::ONE_Q16;
      o.trans = '0;
      o.tir = 1'b1;
      return o;
    end
    q = (rhs - lhs) / (n2 * n2);
    ct = int_sqrt((2 * FB >= 28) ? q << (2 * FB - 28) : q >> (28 - 2 * FB));
    cim = (FB >= 14) ? cmag << (FB - 14) : cmag >> (14 - FB);
    ci = neg ? -longint'(cim) : longint'(cim);
    a = longint'(n1) * ci;
    b = longint'(n2) * longint'(ct);
    rs = ratio_sq(a - b, a + b);
    a = longint'(n1) * longint'(ct);
    b = longint'(n2) * ci;
    rp = ratio_sq(a - b, a + b);
    rf = (rs + rp) >> 1;
    rf = (FB <= 16) ? rf << (16 - FB) : rf >> (FB - 16);
    if (rf > 65536) rf = 65536;
    o.refl = rf[16:0];
    o.trans = 17'(65536 - rf);
    o.tir = 1'b0;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // send one cosine request, prediction queued at acceptance
  // valid stays high after acceptance until the next call or drain
  task automatic send_cosine(logic [15:0] c);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      cos_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cos_valid <= 1'b1;
    incidence_cosine <= c;
    do @(posedge clk); while (!cos_ready);
    expected_fresnel = {expected_fresnel, predict_fresnel(c)};
  endtask

  // result side: random wait after each result, then compare with the oldest prediction
  always @(posedge clk) begin
    fresnel_t w;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_fresnel.size() == 0) begin
          report_mismatch("unexpected result", reflectance, -1);
        end else begin
          w = expected_fresnel.pop_front();
          if (reflectance !== w.refl) report_mismatch("reflectance", reflectance, w.refl);
          if (transmittance !== w.trans)
            report_mismatch("transmittance", transmittance, w.trans);
          if (internal_reflection !== w.tir)
            report_mismatch("internal_reflection", internal_reflection, w.tir);
        end
        out_wait = $urandom_range(0, 1) == 0 ? 0 : $urandom_range(0, 14);
      end
      if (out_wait != 0) begin
        result_ready <= 1'b0;
        out_wait--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // wait for all results, then let the pipe drain
  task automatic drain;
    cos_valid <= 1'b0;
    while (expected_fresnel.size() != 0) @(posedge clk);
    repeat (2 * FB + 50) @(posedge clk);
  endtask

  // write enable stays high; the caller drops it after the last write
  task automatic write_index(logic [fru_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    if (idx == fru_pkg::CFG_INCIDENT_INDEX) n1_model = v;
    else n2_model = v;
  endtask

  // extremes of the cosine, negatives, clamp region, normal incidence
  task automatic test_directed;
    logic [15:0] pts[14] = '{16'h8000, 16'h7fff, 16'd16384, 16'd16385, 16'hc000,
                             16'hbfff, 16'd0, 16'hffff, 16'd1, 16'd8192,
                             16'he000, 16'd16383, 16'hc001, 16'd12000};
    foreach (pts[i]) send_cosine(pts[i]);
  endtask

  // mostly in-range cosines, some out-of-range noise
  task automatic test_random(int count);
    logic [15:0] c;
    repeat (count) begin
      if ($urandom_range(0, 9) < 8) c = 16'($signed($urandom_range(0, 32768)) - 16384);
      else c = 16'($urandom);
      send_cosine(c);
    end
  endtask

  task automatic test_settings;
    // reset values first, then equal and extreme indices and boundaries in both directions
    logic [15:0] n1s[6] = '{16'd16384, 16'd65535, 16'd16384, 16'd65535, 16'd24576, 16'd16384};
    logic [15:0] n2s[6] = '{16'd16384, 16'd16384, 16'd65535, 16'd65535, 16'd16384, 16'd21955};
    test_directed();
    test_random(150);
    drain();
    foreach (n1s[i]) begin
      write_index(fru_pkg::CFG_INCIDENT_INDEX, n1s[i]);
      write_index(fru_pkg::CFG_EXIT_INDEX, n2s[i]);
      cfg_we <= 1'b0;
      test_directed();
      if (i == 0) test_random(150);
      else test_random(110);
      drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_settings();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
sv/fru_pkg.sv
sv/fru_div_cell.sv
sv/fru_sqrt_cell.sv
sv/fresnel_reflectance_unpolarized.sv
tb/testbench.sv
